// File: design/smt_aware_idle_cpu_picker_top_assert.svh
// assertion macros for the idle cpu picker
`ifndef SMT_AWARE_IDLE_CPU_PICKER_TOP_ASSERT_SVH
`define SMT_AWARE_IDLE_CPU_PICKER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SAICP_ASSERT_NOW(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define SAICP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SAICP_ASSERT_NOW(label, clk, rst, expr)
`define SAICP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/saicp_pkg.sv
// types, codes and mask helpers shared by the idle cpu picker
`default_nettype none
package saicp_pkg;

   localparam int MaskW    = 64;
   localparam int CpuW     = 6;
   localparam int CountW   = 7;
   localparam int CsrIdxW  = 4;
   localparam int ReqDataW = 72;
   localparam int RspDataW = 8;
   localparam int Levels   = 6;

   localparam logic [1:0] OP_MARK_IDLE = 2'd0;
   localparam logic [1:0] OP_MARK_BUSY = 2'd1;
   localparam logic [1:0] OP_PICK      = 2'd2;

   localparam logic [1:0] ST_PICKED  = 2'd0;
   localparam logic [1:0] ST_NONE    = 2'd1;
   localparam logic [1:0] ST_UPDATED = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   localparam logic [CsrIdxW-1:0] CSR_CPU_COUNT  = 4'd0;
   localparam logic [CsrIdxW-1:0] CSR_ONLINE     = 4'd1;
   localparam logic [CsrIdxW-1:0] CSR_CORE_START = 4'd2;
   localparam logic [CsrIdxW-1:0] CSR_SMT        = 4'd3;

   typedef struct packed {
      logic [CountW-1:0] cpu_count;
      logic [MaskW-1:0]  online_mask;
      logic [MaskW-1:0]  core_start_mask;
      logic              smt_enabled;
   } cfg_type;

   typedef struct packed {
      logic [MaskW-1:0] idle_mask;
      logic [MaskW-1:0] idle_core_mask;
      logic [CpuW-1:0]  last_picked;
   } state_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [CpuW-1:0]  cpu_id;
      logic [MaskW-1:0] allowed_mask;
      logic             core_only;
   } item_type;

   typedef struct packed {
      logic [CpuW-1:0] picked_cpu;
      logic [1:0]      status;
   } result_type;

   typedef struct packed {
      logic            found;
      logic [CpuW-1:0] cpu;
   } pick_type;

   // ones in the k lowest bits, k up to 64
   function automatic logic [MaskW-1:0] low_bits(logic [CountW-1:0] k);
      logic [MaskW:0] t;
      t = (65'd1 << k) - 65'd1;
      return t[MaskW-1:0];
   endfunction

   function automatic logic [MaskW-1:0] reverse(logic [MaskW-1:0] x);
      logic [MaskW-1:0] r;
      for (int i = 0; i < MaskW; i++) begin
         r[i] = x[MaskW-1-i];
      end
      return r;
   endfunction

   // segmented inclusive prefix or, f marks the first bit of each segment
   function automatic logic [MaskW-1:0] seg_scan(logic [MaskW-1:0] x, logic [MaskW-1:0] f);
      logic [MaskW-1:0] g;
      logic [MaskW-1:0] s;
      logic [MaskW-1:0] gn;
      logic [MaskW-1:0] sn;
      g = x;
      s = f;
      for (int l = 0; l < Levels; l++) begin
         gn = g | (~s & (g << (1 << l)));
         sn = s | (s << (1 << l));
         g  = gn;
         s  = sn;
      end
      return g;
   endfunction

   // or of earlier bits within the same segment
   function automatic logic [MaskW-1:0] seg_excl(logic [MaskW-1:0] x, logic [MaskW-1:0] f);
      return ~f & (seg_scan(x, f) << 1);
   endfunction

   // every bit of a segment that holds any set bit of x
   function automatic logic [MaskW-1:0] spread(logic [MaskW-1:0] x, logic [MaskW-1:0] f);
      logic [MaskW-1:0] e;
      logic [MaskW-1:0] fwd;
      logic [MaskW-1:0] bwd;
      e   = {1'b1, f[MaskW-1:1]};
      fwd = seg_scan(x, f);
      bwd = reverse(seg_scan(reverse(x), reverse(e)));
      return fwd | bwd;
   endfunction

   function automatic pick_type lowest(logic [MaskW-1:0] x);
      logic [MaskW-1:0] iso;
      pick_type         p;
      iso     = x & (~x + 64'd1);
      p.found = |x;
      p.cpu   = '0;
      for (int i = 0; i < MaskW; i++) begin
         p.cpu = p.cpu | (iso[i] ? CpuW'(i) : '0);
      end
      return p;
   endfunction

   // round robin: bits at or above the start first, then wrap to the bottom
   function automatic pick_type rr_first(logic [MaskW-1:0] cand, logic [MaskW-1:0] upper);
      logic [MaskW-1:0] hc;
      hc = cand & upper;
      return lowest((|hc) ? hc : cand);
   endfunction

endpackage
`default_nettype wire

// File: design/saicp_engine.sv
// next-state and result logic for one transaction of the idle cpu picker
`default_nettype none
module saicp_engine #(
   parameter int MAX_CPUS = 64
) (
   input  saicp_pkg::cfg_type    cfg,
   input  saicp_pkg::state_type  state,
   input  saicp_pkg::item_type   item,
   output saicp_pkg::state_type  next_state,
   output saicp_pkg::result_type result
);
   import saicp_pkg::*;

   localparam logic [CountW-1:0] MaxCount = CountW'(MAX_CPUS);

   logic [CountW-1:0] n;
   logic [MaskW-1:0]  valid;
   logic [MaskW-1:0]  fc;
   logic [CountW-1:0] sum;
   logic [CpuW-1:0]   start;
   logic [MaskW-1:0]  sbit;
   logic [MaskW-1:0]  lo_mask;
   logic [MaskW-1:0]  hi_mask;
   logic [MaskW-1:0]  allowed;
   logic [MaskW-1:0]  s_set;
   logic [MaskW-1:0]  core_s;
   logic              wrap_hit;
   logic [MaskW-1:0]  ex;
   logic [MaskW-1:0]  rep;
   pick_type          p1;
   pick_type          p2;
   logic [MaskW-1:0]  upto;
   logic [MaskW-1:0]  prefix;
   logic [MaskW-1:0]  cleared;
   logic [MaskW-1:0]  core1;
   logic [CpuW-1:0]   sel_cpu;
   logic [MaskW-1:0]  core_x;
   logic [MaskW-1:0]  cid_bit;
   logic [MaskW-1:0]  on;
   logic [MaskW-1:0]  idle_set;

   always_comb begin
      n       = (cfg.cpu_count > MaxCount) ? MaxCount : cfg.cpu_count;
      valid   = low_bits(n);
      // bits past the count stand as single-bit segments of their own
      fc      = (cfg.core_start_mask & valid) | ~valid | 64'd1;
      sum     = {1'b0, state.last_picked} + 7'd1;
      start   = (sum >= n) ? '0 : sum[CpuW-1:0];
      sbit    = 64'd1 << start;
      lo_mask = low_bits({1'b0, start});
      hi_mask = valid & ~lo_mask;
      allowed = item.allowed_mask & valid;

      // whole-core search: first hit of each core in round robin order
      s_set    = state.idle_core_mask & allowed;
      core_s   = spread(sbit, fc) & valid;
      wrap_hit = |(s_set & hi_mask & core_s);
      ex       = seg_excl(s_set, fc | sbit);
      rep      = s_set & ~ex & ~({MaskW{wrap_hit}} & core_s & lo_mask);
      p1       = rr_first(rep & state.idle_mask, hi_mask);
      upto     = low_bits({1'b0, p1.cpu} + 7'd1);
      if (!p1.found) begin
         prefix = '1;
      end else if (p1.cpu >= start) begin
         prefix = upto & ~lo_mask;
      end else begin
         prefix = hi_mask | upto;
      end
      // every core visited before the claim leaves the idle-core mask
      cleared = spread(rep & prefix, fc) & valid;
      core1   = state.idle_core_mask & ~cleared;

      // plain idle search, shares the core lookup with the mark path
      p2       = rr_first(state.idle_mask & allowed, hi_mask);
      sel_cpu  = (item.op == OP_PICK) ? p2.cpu : item.cpu_id;
      core_x   = spread(64'd1 << sel_cpu, fc) & valid;
      cid_bit  = 64'd1 << item.cpu_id;
      on       = core_x & cfg.online_mask;
      idle_set = state.idle_mask | cid_bit;
   end

   always_comb begin
      next_state = state;
      result     = '{picked_cpu: '0, status: ST_NONE};
      unique case (item.op)
         OP_MARK_IDLE: begin
            if ({1'b0, item.cpu_id} >= n) begin
               result.status = ST_RANGE;
            end else begin
               next_state.idle_mask = idle_set;
               if (cfg.smt_enabled && ((on & ~idle_set) == '0)) begin
                  next_state.idle_core_mask = state.idle_core_mask | on;
               end
               result.status = ST_UPDATED;
            end
         end
         OP_MARK_BUSY: begin
            if ({1'b0, item.cpu_id} >= n) begin
               result.status = ST_RANGE;
            end else begin
               next_state.idle_mask = state.idle_mask & ~cid_bit;
               if (cfg.smt_enabled) begin
                  next_state.idle_core_mask = state.idle_core_mask & ~core_x;
               end
               result.status = ST_UPDATED;
            end
         end
         OP_PICK: begin
            if (cfg.smt_enabled) begin
               next_state.idle_core_mask = core1;
            end
            priority if (cfg.smt_enabled && p1.found) begin
               next_state.idle_mask   = state.idle_mask & ~(64'd1 << p1.cpu);
               next_state.last_picked = p1.cpu;
               result                 = '{picked_cpu: p1.cpu, status: ST_PICKED};
            end else if (cfg.smt_enabled && item.core_only) begin
               result.status = ST_NONE;
            end else if (p2.found) begin
               if (cfg.smt_enabled) begin
                  next_state.idle_core_mask = core1 & ~core_x;
               end
               next_state.idle_mask   = state.idle_mask & ~(64'd1 << p2.cpu);
               next_state.last_picked = p2.cpu;
               result                 = '{picked_cpu: p2.cpu, status: ST_PICKED};
            end else begin
               result.status = ST_NONE;
            end
         end
         default: begin
            result.status = ST_NONE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: design/smt_aware_idle_cpu_picker_top.sv
// Idle cpu picker with whole-core tracking for hardware threads.
//
// req channel: one transaction marks a cpu idle, marks it busy, or picks an
// idle cpu from an allowed mask (op in req_tuser). rsp channel: exactly one
// transaction per request, in order, with the claimed cpu and a status.
// csr channel: register writes (cpu count, online mask, core start mask,
// smt enable), always ready; writes are to be taken only while no request
// is in flight, which the user must ensure: the block does not enforce it.
// An accepted request is held in the input register; its response is loaded
// into the output register, which drives rsp_tvalid, when that one is free.
// Throughput: one transaction per cycle while rsp_tready is high; the picker
// state closes its loop through the combinational next-state logic, so each
// request sees the masks left by the one before it.
// Stall: while rsp_tready is low the output register holds its response,
// one more request waits in the input register, then req_tready drops.
// Reset clears the idle and idle-core masks and the round robin pointer
// and restores the register defaults; no clearing pass is needed.
`default_nettype none
`include "smt_aware_idle_cpu_picker_top_assert.svh"
module smt_aware_idle_cpu_picker_top #(
   parameter int MAX_CPUS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // cpu_id, allowed_mask, core_only, zero pad
   input  logic [saicp_pkg::ReqDataW-1:0]   req_tdata,
   // op
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // picked_cpu, zero pad
   output logic [saicp_pkg::RspDataW-1:0]   rsp_tdata,
   // status
   output logic [1:0]                       rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [saicp_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [saicp_pkg::MaskW-1:0]      csr_data
);
   import saicp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff;
   state_type  state_in;
   item_type   item_ff;
   logic       item_valid_ff, item_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       process;
   logic       req_take;

   saicp_engine #(
      .MAX_CPUS(MAX_CPUS)
   ) u_engine (
      .cfg       (cfg_ff),
      .state     (state_ff),
      .item      (item_ff),
      .next_state(state_in),
      .result    (result)
   );

   assign advance       = !rsp_valid_ff || rsp_tready;
   assign process       = item_valid_ff && advance;
   assign req_tready    = !item_valid_ff || advance;
   assign req_take      = req_tvalid && req_tready;
   assign item_valid_in = req_tready ? req_tvalid : item_valid_ff;
   assign rsp_valid_in  = advance ? item_valid_ff : rsp_valid_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.picked_cpu};
   assign rsp_tuser  = rsp_ff.status;
   assign csr_ready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CPU_COUNT:  cfg_in.cpu_count       = csr_data[CountW-1:0];
            CSR_ONLINE:     cfg_in.online_mask     = csr_data;
            CSR_CORE_START: cfg_in.core_start_mask = csr_data;
            CSR_SMT:        cfg_in.smt_enabled     = csr_data[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '{cpu_count: 7'd64, online_mask: '0,
                            core_start_mask: '1, smt_enabled: 1'b0};
         state_ff      <= '0;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (process) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= '{op: req_tuser, cpu_id: req_tdata[5:0],
                      allowed_mask: req_tdata[69:6], core_only: req_tdata[70]};
      end
      if (process) begin
         rsp_ff <= result;
      end
   end

   `SAICP_ASSERT_NEXT(a_claim_clears, clock, reset, process && result.status == ST_PICKED, !state_ff.idle_mask[rsp_ff.picked_cpu])
   `SAICP_ASSERT_NEXT(a_core_no_smt, clock, reset, process && !cfg_ff.smt_enabled, $stable(state_ff.idle_core_mask))
   `SAICP_ASSERT_NEXT(a_core_grow, clock, reset, process && item_ff.op != OP_MARK_IDLE, (state_ff.idle_core_mask & ~$past(state_ff.idle_core_mask)) == '0)
   `SAICP_ASSERT_NEXT(a_item_hold, clock, reset, item_valid_ff && !advance, item_valid_ff)
   `SAICP_ASSERT_NOW(a_zero_cpu, clock, reset, !rsp_valid_ff || rsp_ff.status == ST_PICKED || rsp_ff.picked_cpu == '0)

endmodule
`default_nettype wire

// File: tb/sv/smt_aware_idle_cpu_picker_top_tb.sv
// Self-checking testbench for the smt-aware idle cpu picker, with its own mask predictor
`timescale 1ns / 1ps
module smt_aware_idle_cpu_picker_top_tb;
   import saicp_pkg::*;

   localparam int NumCpus = 64;
   localparam int CycleLimit = 300000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // mirrors the picker: register copies, idle masks and the round robin pointer
   class picker_scoreboard;
      logic [CountW-1:0] cpu_count;
      logic [MaskW-1:0]  online;
      logic [MaskW-1:0]  core_start;
      logic              smt;
      logic [MaskW-1:0]  idle;
      logic [MaskW-1:0]  idle_core;
      logic [CpuW-1:0]   last_pick;
      result_type        expected_q[$];
      int                errors;
      int                n_requests;
      int                n_picked;
      int                n_none;
      int                n_range;

      function new();
         cpu_count  = 7'd64;
         online     = '0;
         core_start = '1;
         smt        = 1'b0;
         idle       = '0;
         idle_core  = '0;
         last_pick  = '0;
      endfunction

      function void apply_csr(logic [CsrIdxW-1:0] idx, logic [MaskW-1:0] val);
         case (idx)
            CSR_CPU_COUNT:  cpu_count  = val[CountW-1:0];
            CSR_ONLINE:     online     = val;
            CSR_CORE_START: core_start = val;
            CSR_SMT:        smt        = val[0];
            default: ;
         endcase
      endfunction

      function int cpu_limit();
         return (int'(cpu_count) > NumCpus) ? NumCpus : int'(cpu_count);
      endfunction

      function logic [MaskW-1:0] low_ones(int n);
         return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      endfunction

      // cpus sharing a core with cpu c; cpu 0 always opens a core
      function logic [MaskW-1:0] core_span(int c, int n);
         int lo;
         int hi;
         lo = c;
         hi = c + 1;
         while (lo > 0 && !core_start[lo]) lo--;
         while (hi < n && !core_start[hi]) hi++;
         return low_ones(hi) & ~low_ones(lo);
      endfunction

      function int rr_search(logic [MaskW-1:0] cand, int n);
         int start;
         int c;
         start = int'(last_pick) + 1;
         if (start >= n) start = 0;
         for (int i = 0; i < n; i++) begin
            c = start + i;
            if (c >= n) c -= n;
            if (cand[c]) return c;
         end
         return n;
      endfunction

      function void note_request(item_type it);
         int               n;
         int               c;
         logic [MaskW-1:0] span;
         logic [MaskW-1:0] on;
         logic [MaskW-1:0] allowed;
         result_type       r;
         n = cpu_limit();
         r.picked_cpu = '0;
         r.status = ST_NONE;
         case (it.op)
            OP_MARK_IDLE, OP_MARK_BUSY: begin
               if (int'(it.cpu_id) >= n) begin
                  r.status = ST_RANGE;
               end else begin
                  span = core_span(int'(it.cpu_id), n);
                  if (it.op == OP_MARK_IDLE) begin
                     idle[it.cpu_id] = 1'b1;
                     if (smt) begin
                        on = span & online;
                        if ((on & ~idle) == '0) idle_core |= on;
                     end
                  end else begin
                     idle[it.cpu_id] = 1'b0;
                     if (smt) idle_core &= ~span;
                  end
                  r.status = ST_UPDATED;
               end
            end
            OP_PICK: begin
               allowed = it.allowed_mask & low_ones(n);
               c = n;
               if (smt) begin
                  // stale whole-core bits are dropped until a truly idle cpu turns up
                  c = rr_search(idle_core & allowed, n);
                  while (c < n) begin
                     idle_core &= ~core_span(c, n);
                     if (idle[c]) break;
                     c = rr_search(idle_core & allowed, n);
                  end
               end
               if (c >= n && !(smt && it.core_only)) begin
                  c = rr_search(idle & allowed, n);
                  if (c < n && smt) idle_core &= ~core_span(c, n);
               end
               if (c < n) begin
                  idle[c] = 1'b0;
                  last_pick = CpuW'(c);
                  r.picked_cpu = CpuW'(c);
                  r.status = ST_PICKED;
               end
            end
            default: ;
         endcase
         n_requests++;
         if (r.status == ST_PICKED) n_picked++;
         else if (r.status == ST_RANGE) n_range++;
         else if (r.status == ST_NONE) n_none++;
         expected_q.push_back(r);
      endfunction

      function void check_response(logic [CpuW-1:0] picked, logic [1:0] status);
         result_type e;
         if (expected_q.size() == 0) begin
            $error("response with nothing expected: picked_cpu %0d status %0d", picked, status);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (status !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, status);
            errors++;
         end
         if (picked !== e.picked_cpu) begin
            $error("picked_cpu mismatch: expected %0d, actual %0d", e.picked_cpu, picked);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic [1:0]          req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [MaskW-1:0]    csr_data = '0;

   picker_scoreboard sb;
   bit               steady = 1'b0;
   int               cycles = 0;
   int               settings_seen = 0;

   smt_aware_idle_cpu_picker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAIL smt_aware_idle_cpu_picker_top");
         $finish;
      end
   end

   function automatic item_type make_item(logic [1:0] op, logic [CpuW-1:0] cpu,
                                          logic [MaskW-1:0] allowed, logic only);
      item_type it;
      it.op = op;
      it.cpu_id = cpu;
      it.allowed_mask = allowed;
      it.core_only = only;
      return it;
   endfunction

   function automatic item_type random_item(int n);
      int               roll;
      logic [1:0]       op;
      logic [CpuW-1:0]  cpu;
      logic [MaskW-1:0] allowed;
      roll = $urandom_range(0, 99);
      if (roll < 40) op = OP_MARK_IDLE;
      else if (roll < 62) op = OP_MARK_BUSY;
      else if (roll < 95) op = OP_PICK;
      else op = OP_UNUSED;
      if (n > 0 && $urandom_range(0, 99) < 85) cpu = CpuW'($urandom_range(0, n - 1));
      else cpu = CpuW'($urandom_range(0, 63));
      roll = $urandom_range(0, 99);
      if (roll < 40) allowed = '1;
      else if (roll < 75) allowed = {$urandom(), $urandom()};
      else if (roll < 90) allowed = {$urandom(), $urandom()} & {$urandom(), $urandom()};
      else allowed = 64'd1 << $urandom_range(0, 63);
      return make_item(op, cpu, allowed, 1'($urandom_range(0, 1)));
   endfunction

   task automatic send_request(input item_type it);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {1'b0, it.core_only, it.allowed_mask, it.cpu_id};
      do @(posedge clock); while (!req_tready);
      sb.note_request(it);
   endtask

   // registers change only with nothing in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [CountW-1:0] count, input logic [MaskW-1:0] online,
                            input logic [MaskW-1:0] starts, input logic smt);
      logic [CsrIdxW-1:0] idx [4];
      logic [MaskW-1:0]   vals [4];
      idx  = '{CSR_CPU_COUNT, CSR_ONLINE, CSR_CORE_START, CSR_SMT};
      vals = '{MaskW'(count), online, starts, MaskW'(smt)};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.apply_csr(idx[i], vals[i]);
      end
      csr_valid <= 1'b0;
      settings_seen++;
   endtask

   // response side with random backpressure, none while steady is set
   initial begin : rsp_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata[CpuW-1:0], rsp_tuser);
      end
   end

   initial begin : stimulus
      int                n_items;
      logic [CountW-1:0] count;
      logic [MaskW-1:0]  online;
      logic [MaskW-1:0]  starts;
      logic              smt;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two-thread cores, walk through whole-core claims and the fallback
      configure(7'd64, '1, 64'h5555_5555_5555_5555, 1'b1);
      send_request(make_item(OP_PICK, 6'd0, '1, 1'b0));
      send_request(make_item(OP_MARK_IDLE, 6'd0, '0, 1'b0));
      send_request(make_item(OP_MARK_IDLE, 6'd1, '0, 1'b0));
      send_request(make_item(OP_MARK_IDLE, 6'd63, '1, 1'b1));
      send_request(make_item(OP_MARK_IDLE, 6'd62, '0, 1'b0));
      send_request(make_item(OP_MARK_IDLE, 6'd5, '0, 1'b0));
      send_request(make_item(OP_PICK, 6'd63, '1, 1'b1));
      send_request(make_item(OP_PICK, 6'd0, '1, 1'b1));
      send_request(make_item(OP_PICK, 6'd0, '1, 1'b1));
      send_request(make_item(OP_PICK, 6'd0, '1, 1'b0));
      send_request(make_item(OP_PICK, 6'd0, '0, 1'b0));
      send_request(make_item(OP_PICK, 6'd0, 64'h1, 1'b0));
      send_request(make_item(OP_MARK_BUSY, 6'd5, '0, 1'b0));
      send_request(make_item(OP_UNUSED, 6'd0, '1, 1'b1));
      send_request(make_item(OP_PICK, 6'd0, '1, 1'b0));
      settle();
      // three cpus in one core, ids past the count
      configure(7'd3, '1, 64'h0, 1'b1);
      send_request(make_item(OP_MARK_IDLE, 6'd3, '0, 1'b0));
      send_request(make_item(OP_MARK_BUSY, 6'd63, '0, 1'b0));
      send_request(make_item(OP_MARK_IDLE, 6'd0, '0, 1'b0));
      send_request(make_item(OP_MARK_IDLE, 6'd1, '0, 1'b0));
      send_request(make_item(OP_MARK_IDLE, 6'd2, '0, 1'b0));
      send_request(make_item(OP_PICK, 6'd0, '1, 1'b1));
      settle();
      // no cpus at all
      configure(7'd0, '1, '1, 1'b0);
      send_request(make_item(OP_MARK_IDLE, 6'd0, '0, 1'b0));
      send_request(make_item(OP_PICK, 6'd0, '1, 1'b0));
      settle();

      for (int p = 0; p < 10; p++) begin
         n_items = 212;
         steady = (p == 3 || p == 6);
         case (p)
            0: begin count = 7'd64; online = '1; starts = 64'h5555_5555_5555_5555; smt = 1'b1; end
            1: begin count = 7'd127; online = {$urandom(), $urandom()};
                     starts = 64'h1111_1111_1111_1111; smt = 1'b1; end
            2: begin count = 7'd1; online = '1; starts = '1; smt = 1'b1; end
            3: begin count = 7'd64; online = '1; starts = '1; smt = 1'b0; end
            4: begin count = 7'd2; online = 64'h2; starts = 64'h1; smt = 1'b1; end
            5: begin count = 7'($urandom_range(2, 64)); online = {$urandom(), $urandom()};
                     starts = {$urandom(), $urandom()}; smt = 1'($urandom_range(0, 1)); end
            6: begin count = 7'd65;
                     online = {$urandom(), $urandom()} | {$urandom(), $urandom()};
                     starts = {$urandom(), $urandom()} & {$urandom(), $urandom()};
                     smt = 1'b1; end
            7: begin count = 7'd0; online = '1; starts = '1; smt = 1'b1; n_items = 30; end
            8: begin count = 7'd64; online = '0; starts = '0; smt = 1'b1; end
            default: begin count = 7'($urandom_range(1, 64)); online = {$urandom(), $urandom()};
                     starts = {$urandom(), $urandom()}; smt = 1'b1; end
         endcase
         configure(count, online, starts, smt);
         for (int k = 0; k < n_items; k++) send_request(random_item(sb.cpu_limit()));
         settle();
      end
      steady = 1'b0;

      if (sb.pending() != 0) begin
         $error("%0d expected responses never arrived", sb.pending());
         sb.errors++;
      end
      $display("covered %0d requests under %0d register settings", sb.n_requests, settings_seen);
      $display("outcomes: %0d claimed, %0d found nothing, %0d out of range, %0d mismatches",
               sb.n_picked, sb.n_none, sb.n_range, sb.errors);
      if (sb.errors == 0) begin
         $display("PASS smt_aware_idle_cpu_picker_top");
      end else begin
         $display("FAIL smt_aware_idle_cpu_picker_top");
      end
      $finish;
   end

endmodule
